/* sv/hcd_pkg.sv */
// hcd_pkg: shared constants, codes and controller/datapath interface types
// for the hall call dispatcher. No dependencies.
package hcd_pkg;

  localparam int FLOORS   = 32;
  localparam int CARS     = 4;
  localparam int CAR_W    = $clog2(CARS);
  localparam int FLOOR_W  = 5;
  localparam int POS_W    = 6;
  localparam int CODE_W   = 2;
  localparam int ROW_W    = CODE_W * FLOORS;
  localparam int CHUNK    = 8;
  localparam int CHUNK_IW = $clog2(CHUNK);
  localparam int CHUNKS   = FLOORS / CHUNK;
  localparam int CHUNK_W  = $clog2(CHUNKS);
  localparam int SCORE_W  = 8;

  localparam logic [CAR_W-1:0]   LAST_CAR   = CAR_W'(CARS - 1);
  localparam logic [CHUNK_W-1:0] LAST_CHUNK = CHUNK_W'(CHUNKS - 1);

  typedef enum logic [1:0] {
    FUNC_STATUS = 2'd0,
    FUNC_HALL   = 2'd1,
    FUNC_DEST   = 2'd2
  } func_t;

  localparam logic [CODE_W-1:0] CODE_HALL_UP   = 2'd1;
  localparam logic [CODE_W-1:0] CODE_HALL_DOWN = 2'd2;

  localparam logic signed [1:0] MOT_IDLE = 2'sb00;
  localparam logic signed [1:0] MOT_UP   = 2'sb01;
  localparam logic signed [1:0] MOT_DOWN = 2'sb11;

  localparam logic signed [SCORE_W-1:0] SCORE_IDLE   = SCORE_W'(FLOORS + 5);
  localparam logic signed [SCORE_W-1:0] SCORE_MATCH  = SCORE_W'(FLOORS + 4);
  localparam logic signed [SCORE_W-1:0] SCORE_OPPOSE = SCORE_W'(FLOORS);
  localparam logic signed [SCORE_W-1:0] SCORE_FLOOR  = SCORE_W'(1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCORE,
    S_PICK,
    S_FB_READ,
    S_FB_SCAN,
    S_FB_END,
    S_ROW_READ,
    S_ROW_WRITE,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_BEST,
    ROW_COUNT
  } row_sel_t;

  typedef struct packed {
    logic                load_item;
    logic                status_write;
    logic                score_step;
    logic                set_fallback;
    logic                row_read;
    row_sel_t            row_sel;
    logic                row_write;
    logic                scan_start;
    logic                scan_step;
    logic                scan_last;
    logic                result_load;
    logic [CAR_W-1:0]    car_idx;
    logic [CHUNK_W-1:0]  chunk_idx;
  } dp_cmd_t;

  typedef struct packed {
    func_t func;
    logic  car_ok;
    logic  floor_ok;
    logic  best_found;
    logic  out_free;
  } dp_status_t;

endpackage

/* sv/hcd_datapath.sv */
// hcd_datapath: request registers, car state, per-car destination rows,
// scoring, fallback chunk scan and the result register. Uses hcd_pkg.
module hcd_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  hcd_pkg::dp_cmd_t                     cmd,
  output hcd_pkg::dp_status_t                  status,
  input  logic [1:0]                           func,
  input  logic [hcd_pkg::CAR_W-1:0]            car,
  input  logic [hcd_pkg::FLOOR_W-1:0]          floor_index,
  input  logic                                 up_dir,
  input  logic [hcd_pkg::POS_W-1:0]            car_floor,
  input  logic signed [1:0]                    car_direction,
  input  logic                                 brakes_on,
  input  logic [hcd_pkg::CODE_W-1:0]           request_code,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic                                 assigned,
  output logic [hcd_pkg::CAR_W-1:0]            assigned_car,
  output logic                                 by_fallback
);
  import hcd_pkg::*;

  // latched request
  func_t                it_func;
  logic [CAR_W-1:0]     it_car;
  logic [FLOOR_W-1:0]   it_floor;
  logic                 it_up;
  logic [POS_W-1:0]     it_pos;
  logic signed [1:0]    it_mot;
  logic                 it_brake;
  logic [CODE_W-1:0]    it_code;

  // per-car state
  logic [POS_W-1:0]     car_position [CARS];
  logic signed [1:0]    car_motion   [CARS];
  logic                 car_braked   [CARS];

  // destination rows, one per car
  logic [ROW_W-1:0]     rows      [CARS];
  logic                 row_valid [CARS];
  logic [ROW_W-1:0]     rd_data;
  logic                 rd_ok;
  logic [ROW_W-1:0]     row_data;
  logic [CAR_W-1:0]     rd_addr;
  logic [CAR_W-1:0]     wr_addr;
  logic [CODE_W-1:0]    wr_code;
  logic [ROW_W-1:0]     wr_data;

  // selection
  logic                 best_found;
  logic [CAR_W-1:0]     best_car;
  logic signed [SCORE_W-1:0] best_score;
  logic [POS_W-1:0]     best_dist;
  logic                 fallback;
  logic                 car_found;
  logic [POS_W-1:0]     car_dist;

  logic [POS_W-1:0]     sel_pos;
  logic signed [1:0]    sel_mot;
  logic                 sel_brk;
  logic [POS_W-1:0]     floor_num;
  logic [POS_W-1:0]     floor_gap;
  logic signed [SCORE_W-1:0] dist_s;
  logic signed [SCORE_W-1:0] score;
  logic                 toward_up;
  logic                 toward_down;
  logic                 score_hit;

  logic                 scan_up;
  logic                 scan_down;
  logic [CHUNK_W-1:0]   phys_chunk;
  logic                 hit;
  logic [FLOOR_W-1:0]   hit_floor;
  logic [POS_W-1:0]     scan_dist;
  logic                 cand_found;
  logic [POS_W-1:0]     cand_dist;

  logic                 car_ok;
  logic                 floor_ok;

  assign car_ok   = int'(it_car) < CARS;
  assign floor_ok = int'(it_floor) < FLOORS;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      it_func  <= func_t'(func);
      it_car   <= car;
      it_floor <= floor_index;
      it_up    <= up_dir;
      it_pos   <= car_floor;
      it_mot   <= car_direction;
      it_brake <= brakes_on;
      it_code  <= request_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CARS; i++) begin
        car_position[i] <= POS_W'(1);
        car_motion[i]   <= MOT_IDLE;
        car_braked[i]   <= 1'b0;
      end
    end else if (cmd.status_write && car_ok) begin
      car_position[it_car] <= it_pos;
      car_motion[it_car]   <= it_mot;
      car_braked[it_car]   <= it_brake;
    end
  end

  assign sel_pos = car_position[cmd.car_idx];
  assign sel_mot = car_motion[cmd.car_idx];
  assign sel_brk = car_braked[cmd.car_idx];

  // scoring of the car under the counter
  always_comb begin
    floor_num   = POS_W'(it_floor) + POS_W'(1);
    floor_gap   = (sel_pos > floor_num) ? sel_pos - floor_num : floor_num - sel_pos;
    dist_s      = $signed({{(SCORE_W - POS_W){1'b0}}, floor_gap});
    toward_down = (sel_pos >= floor_num) && (sel_mot == MOT_DOWN);
    toward_up   = (sel_pos < floor_num) && (sel_mot == MOT_UP);
    if (sel_mot == MOT_IDLE) begin
      score = SCORE_IDLE - dist_s;
    end else if ((toward_down && !it_up) || (toward_up && it_up)) begin
      score = SCORE_MATCH - dist_s;
    end else if (toward_down || toward_up) begin
      score = SCORE_OPPOSE - dist_s;
    end else begin
      score = SCORE_FLOOR;
    end
    score_hit = !sel_brk && (score > best_score);
  end

  // destination row store
  always_comb begin
    case (cmd.row_sel)
      ROW_ITEM: rd_addr = it_car;
      ROW_BEST: rd_addr = best_car;
      default:  rd_addr = cmd.car_idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.row_read) begin
      rd_data <= rows[rd_addr];
      rd_ok   <= row_valid[rd_addr];
    end
    if (cmd.row_write) begin
      rows[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CARS; i++) begin
        row_valid[i] <= 1'b0;
      end
    end else if (cmd.row_write) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  // a row never written reads as all zero
  assign row_data = rd_ok ? rd_data : '0;

  always_comb begin
    if (it_func == FUNC_DEST) begin
      wr_addr = it_car;
      wr_code = it_code;
    end else begin
      wr_addr = best_car;
      wr_code = it_up ? CODE_HALL_UP : CODE_HALL_DOWN;
    end
    wr_data = row_data;
    wr_data[{it_floor, 1'b0} +: CODE_W] = wr_code;
  end

  // fallback: up cars scan chunks high to low for the highest floor,
  // down cars scan low to high for the lowest floor
  always_comb begin
    logic [FLOOR_W-1:0]  j;
    logic [CHUNK_IW-1:0] bi;
    logic                elig;
    scan_up    = (sel_mot == MOT_UP);
    scan_down  = (sel_mot == MOT_DOWN);
    phys_chunk = scan_up ? LAST_CHUNK - cmd.chunk_idx : cmd.chunk_idx;
    hit        = 1'b0;
    hit_floor  = '0;
    for (int b = 0; b < CHUNK; b++) begin
      bi = scan_up ? CHUNK_IW'(b) : CHUNK_IW'(CHUNK - 1 - b);
      j  = {phys_chunk, bi};
      elig = (scan_up && ({1'b0, j} > sel_pos)) ||
             (scan_down && ((POS_W'(j) + POS_W'(1)) < sel_pos));
      if (elig && (|row_data[{j, 1'b0} +: CODE_W])) begin
        hit       = 1'b1;
        hit_floor = j;
      end
    end
    scan_dist  = scan_up ? POS_W'(hit_floor) - sel_pos : sel_pos - POS_W'(hit_floor);
    cand_found = car_found || hit;
    cand_dist  = car_found ? car_dist : scan_dist;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_found <= 1'b0;
      fallback   <= 1'b0;
      car_found  <= 1'b0;
    end else begin
      if (cmd.load_item) begin
        best_found <= 1'b0;
        best_score <= SCORE_FLOOR;
        best_dist  <= POS_W'(FLOORS);
        fallback   <= 1'b0;
      end
      if (cmd.score_step && score_hit) begin
        best_found <= 1'b1;
        best_car   <= cmd.car_idx;
        best_score <= score;
      end
      if (cmd.set_fallback) begin
        fallback <= 1'b1;
      end
      if (cmd.scan_start) begin
        car_found <= 1'b0;
      end else if (cmd.scan_step && !car_found && hit) begin
        car_found <= 1'b1;
        car_dist  <= scan_dist;
      end
      if (cmd.scan_last && cand_found && !sel_brk && (cand_dist < best_dist)) begin
        best_found <= 1'b1;
        best_car   <= cmd.car_idx;
        best_dist  <= cand_dist;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      assigned     <= best_found;
      assigned_car <= best_found ? best_car : '0;
      by_fallback  <= best_found && fallback;
    end
  end

  assign status.func       = it_func;
  assign status.car_ok     = car_ok;
  assign status.floor_ok   = floor_ok;
  assign status.best_found = best_found;
  assign status.out_free   = !out_valid || !out_stall;

endmodule

/* sv/hcd_controller.sv */
// hcd_controller: sequencing state machine with the car and chunk counters.
// Uses hcd_pkg; drives hcd_datapath through dp_cmd_t.
module hcd_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  hcd_pkg::dp_status_t status,
  output hcd_pkg::dp_cmd_t    cmd
);
  import hcd_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [CAR_W-1:0]   cnt;
  logic [CAR_W-1:0]   cnt_next;
  logic [CHUNK_W-1:0] chunk;
  logic [CHUNK_W-1:0] chunk_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      chunk <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      chunk <= chunk_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (status.func)
          FUNC_STATUS: state_next = S_DONE;
          FUNC_DEST:   state_next = (status.car_ok && status.floor_ok) ? S_ROW_READ : S_DONE;
          FUNC_HALL:   state_next = status.floor_ok ? S_SCORE : S_DONE;
          default:     state_next = S_DONE;
        endcase
      end
      S_SCORE: begin
        if (cnt == LAST_CAR) state_next = S_PICK;
      end
      S_PICK: begin
        state_next = status.best_found ? S_ROW_READ : S_FB_READ;
      end
      S_FB_READ: begin
        state_next = S_FB_SCAN;
      end
      S_FB_SCAN: begin
        if (chunk == LAST_CHUNK) state_next = (cnt == LAST_CAR) ? S_FB_END : S_FB_READ;
      end
      S_FB_END: begin
        state_next = status.best_found ? S_ROW_READ : S_DONE;
      end
      S_ROW_READ: begin
        state_next = S_ROW_WRITE;
      end
      S_ROW_WRITE: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.row_sel   = ROW_COUNT;
    cmd.car_idx   = cnt;
    cmd.chunk_idx = chunk;
    cnt_next      = cnt;
    chunk_next    = chunk;
    case (state)
      S_IDLE: begin
        cmd.load_item = in_valid;
      end
      S_DISPATCH: begin
        cmd.status_write = (status.func == FUNC_STATUS);
        cnt_next         = '0;
      end
      S_SCORE: begin
        cmd.score_step = 1'b1;
        cnt_next       = cnt + CAR_W'(1);
      end
      S_PICK: begin
        cmd.set_fallback = !status.best_found;
        cnt_next         = '0;
      end
      S_FB_READ: begin
        cmd.row_read   = 1'b1;
        cmd.scan_start = 1'b1;
        chunk_next     = '0;
      end
      S_FB_SCAN: begin
        cmd.scan_step = 1'b1;
        chunk_next    = chunk + CHUNK_W'(1);
        if (chunk == LAST_CHUNK) begin
          cmd.scan_last = 1'b1;
          cnt_next      = cnt + CAR_W'(1);
        end
      end
      S_ROW_READ: begin
        cmd.row_read = 1'b1;
        cmd.row_sel  = (status.func == FUNC_DEST) ? ROW_ITEM : ROW_BEST;
      end
      S_ROW_WRITE: begin
        cmd.row_write = 1'b1;
      end
      S_DONE: begin
        cmd.result_load = status.out_free;
      end
      default: begin
        cmd.row_sel = ROW_COUNT;
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

`ifndef SYNTHESIS
  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    state == S_ROW_WRITE |-> $past(state) == S_ROW_READ)
    else $error("row write without a preceding row read");

  a_scan_only_hall: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCORE || state == S_FB_SCAN) |-> status.func == FUNC_HALL)
    else $error("car scan outside a hall call");

  a_hall_write_has_car: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROW_WRITE && status.func == FUNC_HALL) |-> status.best_found)
    else $error("hall call marked without a chosen car");

  a_scan_starts_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_FB_SCAN && chunk == '0) |-> $past(state) == S_FB_READ)
    else $error("fallback scan started without a row read");
`endif

endmodule

/* sv/hall_call_dispatcher_core.sv */
// hall_call_dispatcher_core: top level of the lift group dispatcher.
// Instantiates hcd_controller and hcd_datapath; uses hcd_pkg.
//
//  channel   direction  handshake            payload
//  in        input      in_valid / in_stall  func car floor_index up_dir car_floor
//                                            car_direction brakes_on request_code
//  out       output     out_valid/out_stall  assigned assigned_car by_fallback
//
// status update: accept, dispatch, then the result; destination write adds a row read
// and a row write; hall call won by score: one scoring step per car, then the pick,
// row read and row write; fallback adds per car one row read, then four 8-floor chunk
// checks, and one closing step; a call left unassigned skips the row read and write
// one request is in work at a time; the next is taken once the result is in the
// output register, which holds it while out_stall is high
// reset (rst, synchronous) returns every car to floor one, idle, no brakes,
// and marks all destination rows empty at once
module hall_call_dispatcher_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  func,
  input  logic [hcd_pkg::CAR_W-1:0]   car,
  input  logic [hcd_pkg::FLOOR_W-1:0] floor_index,
  input  logic                        up_dir,
  input  logic [hcd_pkg::POS_W-1:0]   car_floor,
  input  logic signed [1:0]           car_direction,
  input  logic                        brakes_on,
  input  logic [hcd_pkg::CODE_W-1:0]  request_code,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        assigned,
  output logic [hcd_pkg::CAR_W-1:0]   assigned_car,
  output logic                        by_fallback
);
  import hcd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  hcd_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  hcd_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .func          (func),
    .car           (car),
    .floor_index   (floor_index),
    .up_dir        (up_dir),
    .car_floor     (car_floor),
    .car_direction (car_direction),
    .brakes_on     (brakes_on),
    .request_code  (request_code),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .assigned      (assigned),
    .assigned_car  (assigned_car),
    .by_fallback   (by_fallback)
  );

endmodule

/* bench/hall_call_dispatcher_core_test.sv */
// hall_call_dispatcher_core_test: self-checking bench for the lift group dispatcher.
// Predicts each result from its own copy of car state and destination codes.
// Depends on hcd_pkg and hall_call_dispatcher_core only.
module hall_call_dispatcher_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hcd_pkg::*;

  localparam logic [1:0]        FUNC_SPARE     = 2'd3;
  localparam logic [CODE_W-1:0] CODE_NONE      = 2'd0;
  localparam logic [CODE_W-1:0] CODE_CABIN     = 2'd3;
  localparam logic [1:0]        MOT_SPARE      = 2'b10;
  localparam int                WATCHDOG_LIMIT = 2000;
  localparam int                DRAIN_CYCLES   = 40;

  typedef struct packed {
    logic [1:0]         func;
    logic [CAR_W-1:0]   car;
    logic [FLOOR_W-1:0] floor_index;
    logic               up_dir;
    logic [POS_W-1:0]   car_floor;
    logic [1:0]         car_direction;
    logic               brakes_on;
    logic [CODE_W-1:0]  request_code;
  } lift_req_t;

  typedef struct packed {
    logic             assigned;
    logic [CAR_W-1:0] car;
    logic             by_fallback;
  } dispatch_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          func = '0;
  logic [CAR_W-1:0]    car = '0;
  logic [FLOOR_W-1:0]  floor_index = '0;
  logic                up_dir = 1'b0;
  logic [POS_W-1:0]    car_floor = '0;
  logic signed [1:0]   car_direction = '0;
  logic                brakes_on = 1'b0;
  logic [CODE_W-1:0]   request_code = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                assigned;
  logic [CAR_W-1:0]    assigned_car;
  logic                by_fallback;

  // own copy of the dispatcher state
  int                  lift_pos[CARS];
  logic [1:0]          lift_motion[CARS];
  logic                lift_braked[CARS];
  logic [CODE_W-1:0]   dest_code[CARS][FLOORS];

  dispatch_t           pending_dispatch[$];
  bit                  failed = 1'b0;
  bit                  idling = 1'b1;
  int                  quiet_cycles = 0;

  hall_call_dispatcher_core uut (.*);

  always #4 clk = ~clk;

  function automatic int lift_score(input int c, input int floor_num, input logic up);
    int  pos;
    int  gap;
    bit  toward_down;
    bit  toward_up;
    pos = lift_pos[c];
    gap = pos > floor_num ? pos - floor_num : floor_num - pos;
    toward_down = (pos >= floor_num) && (lift_motion[c] == MOT_DOWN);
    toward_up = (pos < floor_num) && (lift_motion[c] == MOT_UP);
    if (lift_motion[c] == MOT_IDLE)
      return FLOORS + 5 - gap;
    if ((toward_down && !up) || (toward_up && up))
      return FLOORS + 4 - gap;
    if (toward_down || toward_up)
      return FLOORS - gap;
    return 1;
  endfunction

  // distance to the farthest pending destination ahead of the car
  function automatic int lift_reach(input int c);
    int pos;
    int j;
    pos = lift_pos[c];
    if (lift_motion[c] == MOT_UP) begin
      for (j = FLOORS - 1; j > pos; j--)
        if (dest_code[c][j] != CODE_NONE) return j - pos;
    end else if (lift_motion[c] == MOT_DOWN) begin
      for (j = 0; j < pos - 1 && j < FLOORS; j++)
        if (dest_code[c][j] != CODE_NONE) return pos - j;
    end
    return FLOORS;
  endfunction

  function automatic dispatch_t predict_dispatch(input lift_req_t r);
    dispatch_t res;
    int        floor_num;
    int        best;
    int        top;
    int        d;
    int        c;
    res = '0;
    case (r.func)
      FUNC_STATUS: begin
        lift_pos[r.car] = int'(r.car_floor);
        lift_motion[r.car] = r.car_direction;
        lift_braked[r.car] = r.brakes_on;
      end
      FUNC_DEST: begin
        dest_code[r.car][r.floor_index] = r.request_code;
      end
      FUNC_HALL: begin
        floor_num = int'(r.floor_index) + 1;
        best = -1;
        top = 1;
        for (c = 0; c < CARS; c++) begin
          if (!lift_braked[c]) begin
            d = lift_score(c, floor_num, r.up_dir);
            if (d > top) begin
              top = d;
              best = c;
            end
          end
        end
        if (best < 0) begin
          top = FLOORS;
          for (c = 0; c < CARS; c++) begin
            if (!lift_braked[c]) begin
              d = lift_reach(c);
              if (d < top) begin
                top = d;
                best = c;
              end
            end
          end
          res.by_fallback = best >= 0;
        end
        if (best >= 0) begin
          dest_code[best][r.floor_index] = r.up_dir ? CODE_HALL_UP : CODE_HALL_DOWN;
          res.assigned = 1'b1;
          res.car = best[CAR_W-1:0];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic lift_req_t random_req();
    lift_req_t r;
    r.func = 2'($urandom_range(0, 3));
    r.car = CAR_W'($urandom_range(0, CARS - 1));
    r.floor_index = FLOOR_W'($urandom_range(0, FLOORS - 1));
    r.up_dir = 1'($urandom_range(0, 1));
    r.car_floor = POS_W'($urandom_range(0, 63));
    r.car_direction = 2'($urandom_range(0, 3));
    r.brakes_on = 1'($urandom_range(0, 1));
    r.request_code = CODE_W'($urandom_range(0, 3));
    return r;
  endfunction

  // unused fields stay random so the block must ignore them
  function automatic lift_req_t status_req(input int c, input int fl, input logic [1:0] mot,
                                           input logic brk);
    lift_req_t r;
    r = random_req();
    r.func = FUNC_STATUS;
    r.car = CAR_W'(c);
    r.car_floor = POS_W'(fl);
    r.car_direction = mot;
    r.brakes_on = brk;
    return r;
  endfunction

  function automatic lift_req_t dest_req(input int c, input int fl, input logic [1:0] code);
    lift_req_t r;
    r = random_req();
    r.func = FUNC_DEST;
    r.car = CAR_W'(c);
    r.floor_index = FLOOR_W'(fl);
    r.request_code = code;
    return r;
  endfunction

  function automatic lift_req_t hall_req(input int fl, input logic up);
    lift_req_t r;
    r = random_req();
    r.func = FUNC_HALL;
    r.floor_index = FLOOR_W'(fl);
    r.up_dir = up;
    return r;
  endfunction

  task automatic send_request(input lift_req_t r);
    int gap;
    @(negedge clk);
    if (idling && $urandom_range(0, 99) < 29) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= r.func;
    car <= r.car;
    floor_index <= r.floor_index;
    up_dir <= r.up_dir;
    car_floor <= r.car_floor;
    car_direction <= r.car_direction;
    brakes_on <= r.brakes_on;
    request_code <= r.request_code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_dispatch.push_back(predict_dispatch(r));
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  // receiver side back-pressure
  always @(negedge clk) begin
    out_stall <= !rst && idling && ($urandom_range(0, 99) < 29);
  end

  always @(posedge clk) begin : result_check
    dispatch_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_dispatch.size() == 0) begin
          $display("%0t: result with no request waiting, actual %0d/%0d/%0d", $time,
                   assigned, assigned_car, by_fallback);
          failed = 1'b1;
        end else begin
          want = pending_dispatch.pop_front();
          check_field("assigned", int'(want.assigned), int'(assigned));
          check_field("assigned_car", int'(want.car), int'(assigned_car));
          check_field("by_fallback", int'(want.by_fallback), int'(by_fallback));
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[hall_call_dispatcher_core] ERROR");
        $finish;
      end
    end
  end

  task automatic test_reset_defaults();
    // every car idle at floor one, ties go to car 0
    send_request(hall_req(0, 1'b1));
    send_request(hall_req(FLOORS - 1, 1'b0));
    send_request('{func: FUNC_SPARE, car: 2'd3, floor_index: 5'd31, up_dir: 1'b1,
                   car_floor: 6'd63, car_direction: 2'b11, brakes_on: 1'b1,
                   request_code: CODE_CABIN});
  endtask

  task automatic test_scoring_extremes();
    send_request(status_req(0, FLOORS, MOT_UP, 1'b0));
    send_request(status_req(1, 1, MOT_DOWN, 1'b0));
    send_request(status_req(2, 63, MOT_IDLE, 1'b0));
    send_request(status_req(3, 0, MOT_SPARE, 1'b0));
    send_request(hall_req(FLOORS - 1, 1'b1));
    send_request(hall_req(0, 1'b0));
    // opposing direction branch
    send_request(status_req(2, 63, MOT_IDLE, 1'b1));
    send_request(status_req(1, 20, MOT_UP, 1'b0));
    send_request(hall_req(29, 1'b0));
    send_request(status_req(3, 0, MOT_IDLE, 1'b0));
    send_request(hall_req(FLOORS - 1, 1'b1));
  endtask

  task automatic test_fallback();
    // every free car moving away from floor 16, or car 3 with the spare motion code
    send_request(status_req(0, 20, MOT_UP, 1'b0));
    send_request(status_req(1, 10, MOT_DOWN, 1'b0));
    send_request(status_req(3, 5, MOT_SPARE, 1'b0));
    send_request(dest_req(0, 28, CODE_CABIN));
    send_request(dest_req(1, 2, CODE_HALL_UP));
    send_request(hall_req(15, 1'b1));
    send_request(dest_req(0, FLOORS - 1, CODE_NONE));
    send_request(hall_req(15, 1'b0));
    // all cars braked
    send_request(status_req(0, 20, MOT_UP, 1'b1));
    send_request(status_req(1, 10, MOT_DOWN, 1'b1));
    send_request(status_req(3, 5, MOT_IDLE, 1'b1));
    send_request(hall_req(7, 1'b1));
  endtask

  task automatic test_random_traffic(input int count);
    int        sent;
    int        kind;
    int        f;
    int        num;
    int        c;
    int        n;
    int        pick;
    lift_req_t r;
    sent = 0;
    while (sent < count) begin
      idling = sent >= 400;
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        // set every car away from the call floor so scoring falls through
        f = $urandom_range(0, FLOORS - 1);
        num = f + 1;
        for (c = 0; c < CARS; c++) begin
          pick = $urandom_range(0, 5);
          if (pick < 2 || (pick < 4 && num == 1))
            r = status_req(c, $urandom_range(num, FLOORS), MOT_UP, 1'b0);
          else if (pick < 4)
            r = status_req(c, $urandom_range(1, num - 1), MOT_DOWN, 1'b0);
          else if (pick == 4)
            r = status_req(c, $urandom_range(1, FLOORS), 2'($urandom_range(0, 3)), 1'b1);
          else
            r = status_req(c, $urandom_range(1, FLOORS), MOT_SPARE, 1'b0);
          send_request(r);
        end
        n = $urandom_range(0, 3);
        repeat (n)
          send_request(dest_req($urandom_range(0, CARS - 1), $urandom_range(0, FLOORS - 1),
                                2'($urandom_range(0, 3))));
        send_request(hall_req(f, 1'($urandom_range(0, 1))));
        sent += CARS + n + 1;
      end else if (kind < 8) begin
        repeat (6) begin
          pick = $urandom_range(0, 2);
          if (pick == 0) begin
            case ($urandom_range(0, 2))
              0: r = status_req($urandom_range(0, CARS - 1), $urandom_range(1, FLOORS),
                                MOT_IDLE, $urandom_range(0, 7) == 0);
              1: r = status_req($urandom_range(0, CARS - 1), $urandom_range(1, FLOORS),
                                MOT_UP, $urandom_range(0, 7) == 0);
              default: r = status_req($urandom_range(0, CARS - 1), $urandom_range(1, FLOORS),
                                      MOT_DOWN, $urandom_range(0, 7) == 0);
            endcase
          end else if (pick == 1)
            r = dest_req($urandom_range(0, CARS - 1), $urandom_range(0, FLOORS - 1),
                         2'($urandom_range(0, 3)));
          else
            r = hall_req($urandom_range(0, FLOORS - 1), 1'($urandom_range(0, 1)));
          send_request(r);
        end
        sent += 6;
      end else begin
        repeat (4) send_request(random_req());
        sent += 4;
      end
    end
    idling = 1'b1;
  endtask

  initial begin
    int c;
    int j;
    for (c = 0; c < CARS; c++) begin
      lift_pos[c] = 1;
      lift_motion[c] = MOT_IDLE;
      lift_braked[c] = 1'b0;
      for (j = 0; j < FLOORS; j++) dest_code[c][j] = CODE_NONE;
    end
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_scoring_extremes();
    test_fallback();
    test_random_traffic(1750);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_dispatch.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed)
      $display("[hall_call_dispatcher_core] OK");
    else
      $display("[hall_call_dispatcher_core] ERROR");
    $finish;
  end

endmodule
